>>> hw/rtl/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

    // Default limits of the layer and mip axes.
    localparam int SRS_MAX_LAYERS = 2048;
    localparam int SRS_MAX_MIPS   = 16;

    // Field widths of the input and result words.
    localparam int LAYER_BASE_W  = 11;
    localparam int LAYER_COUNT_W = 12;
    localparam int MIP_BASE_W    = 4;
    localparam int MIP_COUNT_W   = 5;

    // Depth of the job queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Piece slots of a job, in the order the pieces leave the block.
    localparam int SLOT_LEFT    = 0;  // layer band below the cutter
    localparam int SLOT_RIGHT   = 1;  // layer band above the cutter
    localparam int SLOT_WHOLE   = 2;  // remaining band, not inside the cutter's layers
    localparam int SLOT_MIP_LO  = 3;  // remaining band, mips below the cutter
    localparam int SLOT_MIP_HI  = 4;  // remaining band, mips above the cutter
    localparam int SLOT_MIP_MID = 5;  // remaining band, remaining mips
    localparam int SLOT_N       = 6;

    // One input word: the range to cut and the cutting range.
    typedef struct packed {
        logic [LAYER_BASE_W-1:0]  cut_layer_base;
        logic [LAYER_COUNT_W-1:0] cut_layer_count;
        logic [MIP_BASE_W-1:0]    cut_mip_base;
        logic [MIP_COUNT_W-1:0]   cut_mip_count;
        logic [LAYER_BASE_W-1:0]  with_layer_base;
        logic [LAYER_COUNT_W-1:0] with_layer_count;
        logic [MIP_BASE_W-1:0]    with_mip_base;
        logic [MIP_COUNT_W-1:0]   with_mip_count;
    } t_in_word;

    // One result word: a single piece of the range to cut.
    typedef struct packed {
        logic [LAYER_BASE_W-1:0]  piece_layer_base;
        logic [LAYER_COUNT_W-1:0] piece_layer_count;
        logic [MIP_BASE_W-1:0]    piece_mip_base;
        logic [MIP_COUNT_W-1:0]   piece_mip_count;
        logic                     inside_cutter;
        logic                     last_piece;
    } t_out_word;

    // Width of a queued job: six layer bounds, six mip bounds, the slot mask
    // and the inside flag of the innermost piece.
    function automatic int job_w(input int lw, input int mw);
        return 6 * lw + 6 * mw + SLOT_N + 1;
    endfunction

endpackage

>>> hw/rtl/srs_fifo.sv
`timescale 1ns / 1ps

module srs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage of the queued words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> hw/rtl/srs_front.sv
`timescale 1ns / 1ps

module srs_front
    import srs_pkg::*;
#(
    parameter int MAX_LAYERS = SRS_MAX_LAYERS,
    parameter int MAX_MIPS   = SRS_MAX_MIPS,
    parameter int JOB_W      = job_w($clog2(SRS_MAX_LAYERS + 1), $clog2(SRS_MAX_MIPS + 1))
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_full
);

    localparam int LW  = $clog2(MAX_LAYERS + 1);
    localparam int MW  = $clog2(MAX_MIPS + 1);
    localparam int ALW = ((LW > LAYER_COUNT_W) ? LW : LAYER_COUNT_W) + 1;
    localparam int AMW = ((MW > MIP_COUNT_W) ? MW : MIP_COUNT_W) + 1;

    typedef struct packed {
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
    } t_lspan;

    typedef struct packed {
        logic [MW-1:0] lo;
        logic [MW-1:0] hi;
    } t_mspan;

    typedef struct packed {
        t_lspan            cl;
        t_lspan            wl;
        t_lspan            mid;
        t_mspan            cm;
        t_mspan            wm;
        t_mspan            mmid;
        logic [SLOT_N-1:0] mask;
        logic              mmid_in;
    } t_job;

    // A zero count counts as one; the base is held below the limit and the
    // end saturates at the limit.
    function automatic t_lspan make_lspan(input logic [LAYER_BASE_W-1:0]  base,
                                          input logic [LAYER_COUNT_W-1:0] count);
        logic [ALW-1:0] b;
        logic [ALW-1:0] c;
        logic [ALW-1:0] e;
        t_lspan         s;
        b = ALW'(base);
        c = (count == '0) ? ALW'(1) : ALW'(count);
        if (b >= ALW'(MAX_LAYERS)) begin
            b = ALW'(MAX_LAYERS - 1);
        end
        e = b + c;
        if (e > ALW'(MAX_LAYERS)) begin
            e = ALW'(MAX_LAYERS);
        end
        s.lo = b[LW-1:0];
        s.hi = e[LW-1:0];
        return s;
    endfunction

    function automatic t_mspan make_mspan(input logic [MIP_BASE_W-1:0]  base,
                                          input logic [MIP_COUNT_W-1:0] count);
        logic [AMW-1:0] b;
        logic [AMW-1:0] c;
        logic [AMW-1:0] e;
        t_mspan         s;
        b = AMW'(base);
        c = (count == '0) ? AMW'(1) : AMW'(count);
        if (b >= AMW'(MAX_MIPS)) begin
            b = AMW'(MAX_MIPS - 1);
        end
        e = b + c;
        if (e > AMW'(MAX_MIPS)) begin
            e = AMW'(MAX_MIPS);
        end
        s.lo = b[MW-1:0];
        s.hi = e[MW-1:0];
        return s;
    endfunction

    logic   r_s1_valid, n_s1_valid;
    t_lspan r_cl, r_wl;
    t_mspan r_cm, r_wm;
    logic   w_accept;
    logic   w_left, w_right, w_mid_in;
    logic   w_mleft, w_mright;
    t_job   w_job;

    // The first stage frees up whenever its word moves into the queue.
    assign o_in_ready = !r_s1_valid || !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = r_s1_valid && !i_full;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Clamped spans of both ranges, captured on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cl <= make_lspan(i_in_word.cut_layer_base, i_in_word.cut_layer_count);
            r_wl <= make_lspan(i_in_word.with_layer_base, i_in_word.with_layer_count);
            r_cm <= make_mspan(i_in_word.cut_mip_base, i_in_word.cut_mip_count);
            r_wm <= make_mspan(i_in_word.with_mip_base, i_in_word.with_mip_count);
        end
    end

    // Classification: which cutter edges fall strictly inside the range on
    // each axis, and where the remaining band and mip span lie.
    always_comb begin
        w_left   = (r_wl.lo > r_cl.lo) && (r_wl.lo < r_cl.hi);
        w_right  = (r_wl.hi > r_cl.lo) && (r_wl.hi < r_cl.hi);
        w_mleft  = (r_wm.lo > r_cm.lo) && (r_wm.lo < r_cm.hi);
        w_mright = (r_wm.hi > r_cm.lo) && (r_wm.hi < r_cm.hi);

        w_job.cl     = r_cl;
        w_job.wl     = r_wl;
        w_job.cm     = r_cm;
        w_job.wm     = r_wm;
        w_job.mid.lo = w_left  ? r_wl.lo : r_cl.lo;
        w_job.mid.hi = w_right ? r_wl.hi : r_cl.hi;
        w_job.mmid.lo = w_mleft  ? r_wm.lo : r_cm.lo;
        w_job.mmid.hi = w_mright ? r_wm.hi : r_cm.hi;

        w_mid_in      = (w_job.mid.lo >= r_wl.lo) && (w_job.mid.hi <= r_wl.hi);
        w_job.mmid_in = (w_job.mmid.lo >= r_wm.lo) && (w_job.mmid.hi <= r_wm.hi);

        w_job.mask               = '0;
        w_job.mask[SLOT_LEFT]    = w_left;
        w_job.mask[SLOT_RIGHT]   = w_right;
        w_job.mask[SLOT_WHOLE]   = !w_mid_in;
        w_job.mask[SLOT_MIP_LO]  = w_mid_in && w_mleft;
        w_job.mask[SLOT_MIP_HI]  = w_mid_in && w_mright;
        w_job.mask[SLOT_MIP_MID] = w_mid_in;
    end

    assign o_job = w_job;

endmodule

>>> hw/rtl/srs_back.sv
`timescale 1ns / 1ps

module srs_back
    import srs_pkg::*;
#(
    parameter int MAX_LAYERS = SRS_MAX_LAYERS,
    parameter int MAX_MIPS   = SRS_MAX_MIPS,
    parameter int JOB_W      = job_w($clog2(SRS_MAX_LAYERS + 1), $clog2(SRS_MAX_MIPS + 1))
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    localparam int LW  = $clog2(MAX_LAYERS + 1);
    localparam int MW  = $clog2(MAX_MIPS + 1);
    localparam int LXW = (LW > LAYER_COUNT_W) ? LW : LAYER_COUNT_W;
    localparam int MXW = (MW > MIP_COUNT_W) ? MW : MIP_COUNT_W;

    typedef struct packed {
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
    } t_lspan;

    typedef struct packed {
        logic [MW-1:0] lo;
        logic [MW-1:0] hi;
    } t_mspan;

    typedef struct packed {
        t_lspan            cl;
        t_lspan            wl;
        t_lspan            mid;
        t_mspan            cm;
        t_mspan            wm;
        t_mspan            mmid;
        logic [SLOT_N-1:0] mask;
        logic              mmid_in;
    } t_job;

    t_job              w_in_job;
    t_job              r_job, n_job;
    logic [SLOT_N-1:0] r_mask, n_mask;
    logic [SLOT_N-1:0] w_sel, w_mask_after;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;
    logic              w_can_emit, w_emit;
    t_lspan            w_lay;
    t_mspan            w_mip;
    logic              w_inside;
    logic [LW-1:0]     w_lcount;
    logic [MW-1:0]     w_mcount;
    logic [LXW-1:0]    w_lbase_x, w_lcount_x;
    logic [MXW-1:0]    w_mbase_x, w_mcount_x;

    assign w_in_job = t_job'(i_job);

    // The lowest pending slot is the next piece to leave.
    assign w_sel        = r_mask & (~r_mask + SLOT_N'(1));
    assign w_mask_after = r_mask & ~w_sel;
    assign w_can_emit   = !r_out_valid || i_out_ready;
    assign w_emit       = (r_mask != '0) && w_can_emit;

    // Take the next job as the current one runs out, so jobs follow with no gap.
    assign o_pop = i_job_valid && ((r_mask == '0) || (w_emit && (w_mask_after == '0)));

    // Bounds of the piece in the selected slot.
    always_comb begin
        w_lay    = r_job.mid;
        w_mip    = r_job.cm;
        w_inside = 1'b0;
        priority if (r_mask[SLOT_LEFT]) begin
            w_lay.lo = r_job.cl.lo;
            w_lay.hi = r_job.wl.lo;
        end else if (r_mask[SLOT_RIGHT]) begin
            w_lay.lo = r_job.wl.hi;
            w_lay.hi = r_job.cl.hi;
        end else if (r_mask[SLOT_WHOLE]) begin
            w_lay = r_job.mid;
        end else if (r_mask[SLOT_MIP_LO]) begin
            w_mip.lo = r_job.cm.lo;
            w_mip.hi = r_job.wm.lo;
        end else if (r_mask[SLOT_MIP_HI]) begin
            w_mip.lo = r_job.wm.hi;
            w_mip.hi = r_job.cm.hi;
        end else begin
            w_mip    = r_job.mmid;
            w_inside = r_job.mmid_in;
        end
    end

    // Counts from the bounds, then fitted to the result field widths.
    always_comb begin
        w_lcount   = w_lay.hi - w_lay.lo;
        w_mcount   = w_mip.hi - w_mip.lo;
        w_lbase_x  = LXW'(w_lay.lo);
        w_lcount_x = LXW'(w_lcount);
        w_mbase_x  = MXW'(w_mip.lo);
        w_mcount_x = MXW'(w_mcount);
    end

    // Job, slot mask and output register updates.
    always_comb begin
        n_job       = r_job;
        n_mask      = r_mask;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_mask                    = w_mask_after;
            n_out.piece_layer_base    = w_lbase_x[LAYER_BASE_W-1:0];
            n_out.piece_layer_count   = w_lcount_x[LAYER_COUNT_W-1:0];
            n_out.piece_mip_base      = w_mbase_x[MIP_BASE_W-1:0];
            n_out.piece_mip_count     = w_mcount_x[MIP_COUNT_W-1:0];
            n_out.inside_cutter       = w_inside;
            n_out.last_piece          = (w_mask_after == '0);
            n_out_valid               = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_job  = w_in_job;
            n_mask = w_in_job.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> hw/rtl/subresource_range_splitter.sv
`timescale 1ns / 1ps

// Cuts a layer-by-mip range against a cutting range and sends out the one to
// five pieces that partition it: the layer band below the cutter, the band
// above it, then the remaining band, which is split along mips in the same
// order when it lies within the cutter's layers. Each piece carries an
// inside-cutter flag, and the final piece of an input word carries last_piece.
// The output channel moves one piece per cycle while i_out_ready is high, so
// an input word holds it for its one to five pieces; this single output
// register is what sets the sustained rate. The front end clamps each accepted
// word into a register and classifies it on its way into a small job queue, so
// the front keeps accepting words while the back end drains pieces until the
// queue fills. An accepted word passes the input register, the job queue, the
// job register and the output register on its way to its first piece.
module subresource_range_splitter
    import srs_pkg::*;
#(
    parameter int MAX_LAYERS = SRS_MAX_LAYERS,
    parameter int MAX_MIPS   = SRS_MAX_MIPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int JOB_W = job_w($clog2(MAX_LAYERS + 1), $clog2(MAX_MIPS + 1));

    logic             w_push, w_full, w_pop, w_empty;
    logic [JOB_W-1:0] w_wjob, w_rjob;

    // Front end: clamps and classifies each word into a job.
    srs_front #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_MIPS   (MAX_MIPS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_push     (w_push),
        .o_job      (w_wjob),
        .i_full     (w_full)
    );

    // Job queue between the two ends.
    srs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wjob),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rjob),
        .o_empty (w_empty)
    );

    // Back end: walks each job's pieces out through the output register.
    srs_back #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_MIPS   (MAX_MIPS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_rjob),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Only the innermost piece can lie inside the cutter, and it always comes last.
    a_inside_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.inside_cutter |-> o_out_word.last_piece)
        else $error("inside_cutter set on a piece that is not the last one");

    // Reset leaves no word on the output.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The back end takes a job only when the queue holds one.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job taken from an empty queue");

    // The front end never writes into a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> !w_full)
        else $error("job written into a full queue");

endmodule
